// ----- sv/zvsm_pkg.sv -----
// ----------------------------------------------------------------------------
// zvsm_pkg
// Shared types and constants for the zvs monitor with adaptive dead time.
// ----------------------------------------------------------------------------
package zvsm_pkg;

    // default widths
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF  = 16;

    // config port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SENSE_ENABLE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VDS_THRESHOLD  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIP_LIMIT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_DEADTIME = 4'd3;

    // register reset values
    localparam logic [11:0] THR_RST      = 12'd0;
    localparam logic [15:0] FAIL_LIM_RST = 16'd50;
    localparam logic [11:0] START_DT_RST = 12'd100;

    // dead time clamp in ns
    localparam logic [11:0] DT_MIN = 12'd50;
    localparam logic [11:0] DT_MAX = 12'd2000;

    // input command
    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_ADAPT    = 1'b1;

    typedef enum logic [1:0] {
        CLS_UNKNOWN  = 2'd0,
        CLS_ACHIEVED = 2'd1,
        CLS_MARGINAL = 2'd2,
        CLS_HARD     = 2'd3
    } t_zvs_class;

    // current register contents
    typedef struct packed {
        logic        sense_enable;
        logic [11:0] vds_threshold;
        logic [15:0] trip_limit;
    } t_cfg;

    // one-cycle events raised by a register write
    typedef struct packed {
        logic        clear_sense;
        logic        load_dt;
        logic [11:0] load_value;
    } t_cfg_evt;

    // one result word
    typedef struct packed {
        t_zvs_class  zvs_class;
        logic        trip;
        logic [11:0] deadtime_now;
        logic        deadtime_changed;
    } t_result;

endpackage

// ----- sv/zvs_monitor_adaptive_deadtime.sv -----
// ----------------------------------------------------------------------------
// zvs_monitor_adaptive_deadtime
// ZVS monitor: classifies end-of-dead-time Vds samples, counts failures for
// an emergency trip, and adapts the dead time on command.
//
//   channel  direction  handshake                    payload
//   in       sink       i_in_valid / o_in_stall      i_cmd, i_vds_code
//   out      source     o_out_valid / i_out_stall    o_zvs_class, o_trip,
//                                                    o_deadtime_now,
//                                                    o_deadtime_changed
//   cfg      sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A word is captured in an input register, evaluated against the monitor
// state and lands in the output register; one word per cycle is sustained
// while the output word is not stalled.
// Synchronous active-low reset clears the handshake and monitor state and
// loads the dead time with its reset start value.
// While the output word is stalled the input register still takes one word,
// then o_in_stall rises. Config writes are always taken.
// ----------------------------------------------------------------------------
module zvs_monitor_adaptive_deadtime #(
    parameter int SAMPLE_BITS = zvsm_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = zvsm_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input words
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic [SAMPLE_BITS-1:0]           i_vds_code,
    // result words
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_zvs_class,
    output logic                             o_trip,
    output logic [11:0]                      o_deadtime_now,
    output logic                             o_deadtime_changed,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [zvsm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [zvsm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                   r_s1_valid;
    logic                   n_s1_valid;
    logic                   r_s1_cmd;
    logic [SAMPLE_BITS-1:0] r_s1_vds;
    logic                   r_out_valid;
    logic                   n_out_valid;
    zvsm_pkg::t_result      r_out;
    zvsm_pkg::t_result      core_result;
    zvsm_pkg::t_cfg         cfg;
    zvsm_pkg::t_cfg_evt     cfg_evt;
    logic                   out_free;
    logic                   s1_fire;
    logic                   in_accept;

    zvsm_cfg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_evt       (cfg_evt)
    );

    zvsm_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_fire),
        .i_cmd    (r_s1_cmd),
        .i_vds    (r_s1_vds),
        .i_cfg    (cfg),
        .i_evt    (cfg_evt),
        .o_result (core_result)
    );

    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        s1_fire    = r_s1_valid && out_free;
        o_in_stall = r_s1_valid && !out_free;
        in_accept  = i_in_valid && !o_in_stall;

        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_fire) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end

        if (s1_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd <= i_cmd;
            r_s1_vds <= i_vds_code;
        end
        if (s1_fire) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_zvs_class        = r_out.zvs_class;
    assign o_trip             = r_out.trip;
    assign o_deadtime_now     = r_out.deadtime_now;
    assign o_deadtime_changed = r_out.deadtime_changed;
    assign o_cfg_ready        = 1'b1;

endmodule

// ----- sv/zvsm_cfg.sv -----
// ----------------------------------------------------------------------------
// zvsm_cfg
// Configuration register file; flags writes that restart sensing or reload
// the dead time.
// ----------------------------------------------------------------------------
module zvsm_cfg #(
    parameter int SAMPLE_BITS = zvsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [zvsm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [zvsm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output zvsm_pkg::t_cfg                   o_cfg,
    output zvsm_pkg::t_cfg_evt               o_evt
);

    // threshold keeps only bits that a sample can reach
    localparam logic [11:0] THR_MASK = 12'((33'h1 << SAMPLE_BITS) - 33'h1);

    logic        r_sense_enable;
    logic [11:0] r_vds_threshold;
    logic [15:0] r_trip_limit;
    logic        wr_sense;
    logic        wr_thr;
    logic        wr_lim;
    logic        wr_dt;

    always_comb begin
        wr_sense = i_cfg_valid && (i_cfg_index == zvsm_pkg::REG_SENSE_ENABLE);
        wr_thr   = i_cfg_valid && (i_cfg_index == zvsm_pkg::REG_VDS_THRESHOLD);
        wr_lim   = i_cfg_valid && (i_cfg_index == zvsm_pkg::REG_TRIP_LIMIT);
        wr_dt    = i_cfg_valid && (i_cfg_index == zvsm_pkg::REG_START_DEADTIME);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sense_enable  <= 1'b0;
            r_vds_threshold <= zvsm_pkg::THR_RST;
            r_trip_limit    <= zvsm_pkg::FAIL_LIM_RST;
        end else begin
            if (wr_sense) begin
                r_sense_enable <= i_cfg_data[0];
            end
            if (wr_thr) begin
                r_vds_threshold <= i_cfg_data[11:0] & THR_MASK;
            end
            if (wr_lim) begin
                r_trip_limit <= i_cfg_data[15:0];
            end
        end
    end

    always_comb begin
        o_cfg.sense_enable  = r_sense_enable;
        o_cfg.vds_threshold = r_vds_threshold;
        o_cfg.trip_limit    = r_trip_limit;
        o_evt.clear_sense   = wr_sense || wr_thr || wr_lim;
        o_evt.load_dt       = wr_dt;
        o_evt.load_value    = i_cfg_data[11:0];
    end

endmodule

// ----- sv/zvsm_core.sv -----
// ----------------------------------------------------------------------------
// zvsm_core
// Sample classification, saturating fail count and dead time adaptation.
// Holds the monitor state; the result is combinational from one word.
// ----------------------------------------------------------------------------
module zvsm_core #(
    parameter int SAMPLE_BITS = zvsm_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = zvsm_pkg::COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic                   i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_vds,
    input  zvsm_pkg::t_cfg         i_cfg,
    input  zvsm_pkg::t_cfg_evt     i_evt,
    output zvsm_pkg::t_result      o_result
);

    localparam int CMP_W = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 4;
    localparam int LIM_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [COUNT_BITS-1:0] r_fail_count;
    logic [COUNT_BITS-1:0] n_fail_count;
    zvsm_pkg::t_zvs_class  r_last_class;
    zvsm_pkg::t_zvs_class  n_last_class;
    logic [11:0]           r_deadtime;
    logic [11:0]           n_deadtime;

    logic [CMP_W-1:0] vds_ext;
    logic [CMP_W-1:0] thr_ext;
    logic [CMP_W-1:0] vds_x10;
    logic [CMP_W-1:0] thr_x3;
    logic [12:0]      dt_ext;
    logic [12:0]      dt_sum;
    logic [11:0]      dt_adapt;
    logic             trip_cmp;

    // classify: 10*vds < 3*thr is the exact form of vds < 0.3*thr
    always_comb begin
        vds_ext = CMP_W'(i_vds);
        thr_ext = CMP_W'(i_cfg.vds_threshold);
        vds_x10 = (vds_ext << 3) + (vds_ext << 1);
        thr_x3  = (thr_ext << 1) + thr_ext;
    end

    // adaptation from the last class, then clamp
    always_comb begin
        dt_ext = {1'b0, r_deadtime};
        unique case (r_last_class)
            zvsm_pkg::CLS_HARD: begin
                dt_sum = dt_ext + (dt_ext >> 1);
            end
            zvsm_pkg::CLS_MARGINAL: begin
                dt_sum = dt_ext + (dt_ext >> 3);
            end
            zvsm_pkg::CLS_ACHIEVED: begin
                dt_sum = (r_deadtime > zvsm_pkg::DT_MIN) ? dt_ext - (dt_ext >> 4) : dt_ext;
            end
            default: begin
                dt_sum = dt_ext;
            end
        endcase
        if (dt_sum < {1'b0, zvsm_pkg::DT_MIN}) begin
            dt_adapt = zvsm_pkg::DT_MIN;
        end else if (dt_sum > {1'b0, zvsm_pkg::DT_MAX}) begin
            dt_adapt = zvsm_pkg::DT_MAX;
        end else begin
            dt_adapt = dt_sum[11:0];
        end
    end

    // next state
    always_comb begin
        n_fail_count = r_fail_count;
        n_last_class = r_last_class;
        n_deadtime   = r_deadtime;
        if (i_cfg.sense_enable) begin
            if (i_cmd == zvsm_pkg::CMD_ADAPT) begin
                n_deadtime = dt_adapt;
            end else if (vds_x10 < thr_x3) begin
                n_last_class = zvsm_pkg::CLS_ACHIEVED;
                n_fail_count = '0;
            end else begin
                n_last_class = (vds_ext < thr_ext) ? zvsm_pkg::CLS_MARGINAL
                                                   : zvsm_pkg::CLS_HARD;
                if (r_fail_count != '1) begin
                    n_fail_count = r_fail_count + 1'b1;
                end
            end
        end
    end

    always_comb begin
        trip_cmp = LIM_W'(n_fail_count) >= LIM_W'(i_cfg.trip_limit);
        o_result.deadtime_now     = n_deadtime;
        o_result.trip             = i_cfg.sense_enable && trip_cmp;
        o_result.deadtime_changed = i_cfg.sense_enable && (i_cmd == zvsm_pkg::CMD_ADAPT)
                                    && (dt_adapt != r_deadtime);
        if (i_cfg.sense_enable) begin
            o_result.zvs_class = n_last_class;
        end else if (i_cmd == zvsm_pkg::CMD_ADAPT) begin
            o_result.zvs_class = r_last_class;
        end else begin
            o_result.zvs_class = zvsm_pkg::CLS_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_count <= '0;
            r_last_class <= zvsm_pkg::CLS_UNKNOWN;
            r_deadtime   <= zvsm_pkg::START_DT_RST;
        end else begin
            if (i_evt.clear_sense) begin
                r_fail_count <= '0;
                r_last_class <= zvsm_pkg::CLS_UNKNOWN;
            end else if (i_fire) begin
                r_fail_count <= n_fail_count;
                r_last_class <= n_last_class;
            end
            if (i_evt.load_dt) begin
                r_deadtime <= i_evt.load_value;
            end else if (i_fire) begin
                r_deadtime <= n_deadtime;
            end
        end
    end

endmodule
